FILE: rtl/mhdlo_pkg.sv
// mhdlo_pkg: shared types, codes and defaults for the max-heap block
// holds payload structs, kind and status codes, sequencer states and
// datapath operation codes; depends on nothing
`default_nettype none

package mhdlo_pkg;

    // default sizing of the heap store
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    // operation kinds carried by an input transaction
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_NO_ODD = 2'd2,
        STAT_RANGE  = 2'd3
    } t_status;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] item_value;
        logic [3:0]  entry_index;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [15:0] result_value;
        logic [1:0]  status;
        logic [4:0]  heap_count;
    } t_out_item;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_SCAN,
        S_DEL_DEC,
        S_DEL_LOAD,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_FINISH
    } t_state;

    // datapath operation issued by the controller each cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_UP_RD,
        OP_UP_CMP,
        OP_DN_RDL,
        OP_DN_RDR,
        OP_DN_CMP,
        OP_SCAN,
        OP_DEL_DEC,
        OP_DEL_LOAD,
        OP_RD_ISSUE,
        OP_RD_WAIT,
        OP_FINISH
    } t_op;

    // datapath status flags seen by the controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic up_less;
        logic up_final;
        logic no_left;
        logic dn_stop;
        logic scan_done;
        logic found;
        logic hole_last;
        logic idx_bad;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/mhdlo_ram.sv
// mhdlo_ram: generic single-write, single-read RAM with registered read data
// standalone; defaults from mhdlo_pkg
`default_nettype none

module mhdlo_ram #(
    parameter int WIDTH = mhdlo_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = mhdlo_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/mhdlo_datapath.sv
// mhdlo_datapath: heap store, entry count, sift and scan registers, result register
// depends on mhdlo_pkg and mhdlo_ram; driven by operation codes from mhdlo_ctrl
`default_nettype none

module mhdlo_datapath #(
    parameter int DEPTH       = mhdlo_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = mhdlo_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mhdlo_pkg::t_op        i_op,
    input  wire mhdlo_pkg::t_in_item   i_in,
    input  wire logic                  i_out_ready,
    output mhdlo_pkg::t_stat           o_stat,
    output logic                       o_out_valid,
    output mhdlo_pkg::t_out_item       o_out
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LW   = AW + 2;
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int VW   = VALUE_WIDTH;

    // control registers
    logic [CW-1:0]           r_count,     n_count;
    logic                    r_out_valid, n_out_valid;

    // payload registers
    logic [VW-1:0]           r_val,       n_val;
    logic [AW-1:0]           r_pos,       n_pos;
    logic                    r_moved,     n_moved;
    logic                    r_ins,       n_ins;
    logic [VW-1:0]           r_left,      n_left;
    logic [VW-1:0]           r_best,      n_best;
    logic [AW-1:0]           r_hole,      n_hole;
    logic                    r_found,     n_found;
    logic [CW-1:0]           r_scan_addr, n_scan_addr;
    logic [AW-1:0]           r_cmp_addr,  n_cmp_addr;
    logic                    r_cmp_vld,   n_cmp_vld;
    logic [3:0]              r_index,     n_index;
    logic [15:0]             r_res_val,   n_res_val;
    mhdlo_pkg::t_status      r_res_stat,  n_res_stat;
    mhdlo_pkg::t_out_item    r_out,       n_out;

    // memory port signals
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [VW-1:0]           w_wdata;
    logic                    w_re;
    logic [AW-1:0]           w_raddr;
    logic [VW-1:0]           w_rdata;

    // heap index arithmetic
    logic [LW-1:0]           w_left_idx;
    logic [LW-1:0]           w_right_idx;
    logic [LW-1:0]           w_cnt_l;
    logic [AW-1:0]           w_parent;
    logic                    w_has_right;
    logic                    w_left_big;
    logic [VW-1:0]           w_cand_val;
    logic                    w_right_best;
    logic                    w_dn_stop;
    logic                    w_full;
    logic                    w_out_free;

    mhdlo_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // child and parent positions of the current sift position
    assign w_left_idx  = {1'b0, r_pos, 1'b1};
    assign w_right_idx = w_left_idx + LW'(1);
    assign w_cnt_l     = LW'(r_count);
    assign w_parent    = AW'((r_pos - AW'(1)) >> 1);
    assign w_has_right = w_right_idx < w_cnt_l;

    // pick the larger child against the moving value, left wins a tie with right
    assign w_left_big   = r_left > r_val;
    assign w_cand_val   = w_left_big ? r_left : r_val;
    assign w_right_best = w_has_right && (w_rdata > w_cand_val);
    assign w_dn_stop    = !w_left_big && !w_right_best;

    assign w_full     = r_count == CW'(DEPTH);
    assign w_out_free = !r_out_valid || i_out_ready;

    // status to the controller
    always_comb begin
        o_stat.full      = w_full;
        o_stat.pos_zero  = r_pos == '0;
        o_stat.up_less   = w_rdata < r_val;
        o_stat.up_final  = r_ins || r_moved;
        o_stat.no_left   = w_left_idx >= w_cnt_l;
        o_stat.dn_stop   = w_dn_stop;
        o_stat.scan_done = (r_scan_addr == r_count) && !r_cmp_vld;
        o_stat.found     = r_found;
        o_stat.hole_last = CW'(r_hole) >= (r_count - CW'(1));
        o_stat.idx_bad   = CMPW'(r_index) >= CMPW'(r_count);
        o_stat.out_free  = w_out_free;
    end

    // next-state logic of the datapath registers and memory ports
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_val       = r_val;
        n_pos       = r_pos;
        n_moved     = r_moved;
        n_ins       = r_ins;
        n_left      = r_left;
        n_best      = r_best;
        n_hole      = r_hole;
        n_found     = r_found;
        n_scan_addr = r_scan_addr;
        n_cmp_addr  = r_cmp_addr;
        n_cmp_vld   = r_cmp_vld;
        n_index     = r_index;
        n_res_val   = r_res_val;
        n_res_stat  = r_res_stat;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_val;
        w_re        = 1'b0;
        w_raddr     = '0;

        case (i_op)
            // latch the transaction and start the insert or the scan
            mhdlo_pkg::OP_ACCEPT: begin
                n_index    = i_in.entry_index;
                n_res_val  = '0;
                n_res_stat = mhdlo_pkg::STAT_OK;
                case (i_in.kind)
                    mhdlo_pkg::KIND_INSERT: begin
                        if (w_full) begin
                            n_res_stat = mhdlo_pkg::STAT_FULL;
                        end else begin
                            n_val   = VW'(i_in.item_value);
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            n_ins   = 1'b1;
                            n_moved = 1'b0;
                        end
                    end
                    mhdlo_pkg::KIND_DELETE: begin
                        n_found     = 1'b0;
                        n_scan_addr = '0;
                        n_cmp_vld   = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // sift up: fetch the parent, or settle at the root
            mhdlo_pkg::OP_UP_RD: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_parent;
                end
            end

            // sift up: move the parent down or settle here
            mhdlo_pkg::OP_UP_CMP: begin
                if (w_rdata < r_val) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_pos   = w_parent;
                    n_moved = 1'b1;
                end else if (r_ins || r_moved) begin
                    w_we = 1'b1;
                end
            end

            // sift down: fetch the left child, or settle at a leaf
            mhdlo_pkg::OP_DN_RDL: begin
                if (w_left_idx >= w_cnt_l) begin
                    w_we = 1'b1;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_left_idx);
                end
            end

            // sift down: keep the left child, fetch the right one
            mhdlo_pkg::OP_DN_RDR: begin
                n_left = w_rdata;
                if (w_has_right) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_right_idx);
                end
            end

            // sift down: move the larger child up or settle here
            mhdlo_pkg::OP_DN_CMP: begin
                w_we = 1'b1;
                if (!w_dn_stop) begin
                    w_wdata = w_right_best ? w_rdata : r_left;
                    n_pos   = w_right_best ? AW'(w_right_idx) : AW'(w_left_idx);
                end
            end

            // scan: one read issued and one compare done each cycle
            mhdlo_pkg::OP_SCAN: begin
                if (r_scan_addr < r_count) begin
                    w_re        = 1'b1;
                    w_raddr     = AW'(r_scan_addr);
                    n_cmp_addr  = AW'(r_scan_addr);
                    n_scan_addr = r_scan_addr + CW'(1);
                    n_cmp_vld   = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld && w_rdata[0] && (!r_found || (w_rdata > r_best))) begin
                    n_found = 1'b1;
                    n_best  = w_rdata;
                    n_hole  = r_cmp_addr;
                end
            end

            // delete: report, shrink, fetch the last entry if it must move
            mhdlo_pkg::OP_DEL_DEC: begin
                if (!r_found) begin
                    n_res_stat = mhdlo_pkg::STAT_NO_ODD;
                end else begin
                    n_res_val = 16'(r_best);
                    n_count   = r_count - CW'(1);
                    if (CW'(r_hole) < (r_count - CW'(1))) begin
                        w_re    = 1'b1;
                        w_raddr = AW'(r_count - CW'(1));
                    end
                end
            end

            // delete: the last entry starts sifting from the hole
            mhdlo_pkg::OP_DEL_LOAD: begin
                n_val   = w_rdata;
                n_pos   = r_hole;
                n_moved = 1'b0;
                n_ins   = 1'b0;
            end

            // read: range check and fetch
            mhdlo_pkg::OP_RD_ISSUE: begin
                if (CMPW'(r_index) >= CMPW'(r_count)) begin
                    n_res_stat = mhdlo_pkg::STAT_RANGE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_index);
                end
            end

            mhdlo_pkg::OP_RD_WAIT: begin
                n_res_val = 16'(w_rdata);
            end

            // hand the result to the output register
            mhdlo_pkg::OP_FINISH: begin
                if (w_out_free) begin
                    n_out.result_value = r_res_val;
                    n_out.status       = r_res_stat;
                    n_out.heap_count   = 5'(r_count);
                    n_out_valid        = 1'b1;
                end
            end

            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_pos       <= n_pos;
        r_moved     <= n_moved;
        r_ins       <= n_ins;
        r_left      <= n_left;
        r_best      <= n_best;
        r_hole      <= n_hole;
        r_found     <= n_found;
        r_scan_addr <= n_scan_addr;
        r_cmp_addr  <= n_cmp_addr;
        r_cmp_vld   <= n_cmp_vld;
        r_index     <= n_index;
        r_res_val   <= n_res_val;
        r_res_stat  <= n_res_stat;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a successful insert grows the heap by exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == mhdlo_pkg::OP_ACCEPT) && (i_in.kind == mhdlo_pkg::KIND_INSERT) && !w_full
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the heap by one");

    // a found odd entry shrinks the heap by exactly one entry
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == mhdlo_pkg::OP_DEL_DEC) && r_found
        |=> r_count == $past(r_count) - 1'b1)
        else $error("delete did not shrink the heap by one");

    // sift up only moves toward the root
    a_up_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == mhdlo_pkg::OP_UP_CMP) && (w_rdata < r_val)
        |=> r_pos < $past(r_pos))
        else $error("sift up did not move toward the root");

    // sift down only moves toward the leaves
    a_down_moves_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == mhdlo_pkg::OP_DN_CMP) && !w_dn_stop
        |=> r_pos > $past(r_pos))
        else $error("sift down did not move toward the leaves");

endmodule

`default_nettype wire

FILE: rtl/mhdlo_ctrl.sv
// mhdlo_ctrl: sequencer for insert, delete-largest-odd and read transactions
// depends on mhdlo_pkg; issues operation codes to mhdlo_datapath
`default_nettype none

module mhdlo_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_kind,
    input  wire mhdlo_pkg::t_stat  i_stat,
    output logic                   o_in_ready,
    output mhdlo_pkg::t_op         o_op
);

    mhdlo_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhdlo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and operation
    always_comb begin
        n_state    = r_state;
        o_op       = mhdlo_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            mhdlo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = mhdlo_pkg::OP_ACCEPT;
                    case (i_kind)
                        mhdlo_pkg::KIND_INSERT: begin
                            n_state = i_stat.full ? mhdlo_pkg::S_FINISH : mhdlo_pkg::S_UP_RD;
                        end
                        mhdlo_pkg::KIND_DELETE: n_state = mhdlo_pkg::S_SCAN;
                        mhdlo_pkg::KIND_READ:   n_state = mhdlo_pkg::S_RD_ISSUE;
                        default:                n_state = mhdlo_pkg::S_FINISH;
                    endcase
                end
            end
            mhdlo_pkg::S_UP_RD: begin
                o_op = mhdlo_pkg::OP_UP_RD;
                // an entry moved into the root hole still has to sift down
                if (i_stat.pos_zero) begin
                    n_state = i_stat.up_final ? mhdlo_pkg::S_FINISH : mhdlo_pkg::S_DN_RDL;
                end else begin
                    n_state = mhdlo_pkg::S_UP_CMP;
                end
            end
            mhdlo_pkg::S_UP_CMP: begin
                o_op = mhdlo_pkg::OP_UP_CMP;
                if (i_stat.up_less) begin
                    n_state = mhdlo_pkg::S_UP_RD;
                end else if (i_stat.up_final) begin
                    n_state = mhdlo_pkg::S_FINISH;
                end else begin
                    n_state = mhdlo_pkg::S_DN_RDL;
                end
            end
            mhdlo_pkg::S_DN_RDL: begin
                o_op    = mhdlo_pkg::OP_DN_RDL;
                n_state = i_stat.no_left ? mhdlo_pkg::S_FINISH : mhdlo_pkg::S_DN_RDR;
            end
            mhdlo_pkg::S_DN_RDR: begin
                o_op    = mhdlo_pkg::OP_DN_RDR;
                n_state = mhdlo_pkg::S_DN_CMP;
            end
            mhdlo_pkg::S_DN_CMP: begin
                o_op    = mhdlo_pkg::OP_DN_CMP;
                n_state = i_stat.dn_stop ? mhdlo_pkg::S_FINISH : mhdlo_pkg::S_DN_RDL;
            end
            mhdlo_pkg::S_SCAN: begin
                o_op = mhdlo_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = mhdlo_pkg::S_DEL_DEC;
                end
            end
            mhdlo_pkg::S_DEL_DEC: begin
                o_op = mhdlo_pkg::OP_DEL_DEC;
                if (!i_stat.found || i_stat.hole_last) begin
                    n_state = mhdlo_pkg::S_FINISH;
                end else begin
                    n_state = mhdlo_pkg::S_DEL_LOAD;
                end
            end
            mhdlo_pkg::S_DEL_LOAD: begin
                o_op    = mhdlo_pkg::OP_DEL_LOAD;
                n_state = mhdlo_pkg::S_UP_RD;
            end
            mhdlo_pkg::S_RD_ISSUE: begin
                o_op    = mhdlo_pkg::OP_RD_ISSUE;
                n_state = i_stat.idx_bad ? mhdlo_pkg::S_FINISH : mhdlo_pkg::S_RD_WAIT;
            end
            mhdlo_pkg::S_RD_WAIT: begin
                o_op    = mhdlo_pkg::OP_RD_WAIT;
                n_state = mhdlo_pkg::S_FINISH;
            end
            mhdlo_pkg::S_FINISH: begin
                o_op = mhdlo_pkg::OP_FINISH;
                if (i_stat.out_free) begin
                    n_state = mhdlo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhdlo_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/max_heap_delete_largest_odd.sv
// max_heap_delete_largest_odd: top level of the binary max-heap block
// depends on mhdlo_pkg, mhdlo_ctrl, mhdlo_datapath (which holds mhdlo_ram)
//
//  - input channel i_in_valid / o_in_ready carries t_in_item: kind, item_value,
//    entry_index; output channel o_out_valid / i_out_ready carries t_out_item:
//    result_value, status, heap_count. one result per input transaction
//  - one transaction is in work at a time; o_in_ready is high only while idle,
//    and a result may still wait in the output register while the next
//    transaction is taken
//  - insert: the value sifts up from the new last slot; a full heap answers
//    with STAT_FULL and leaves the store untouched
//  - delete: a scan of the live entries finds the largest odd one, which is
//    reported as the heap shrinks; a moved last entry is loaded into the hole and sifts up or down to settle
//  - read: range check, then fetch; an out-of-range index answers with STAT_RANGE
//  - reset clears the entry count and the output valid; the store itself is
//    not cleared and only live entries are ever read
//  - when the receiver stalls, the finished result waits in the sequencer
//    until the output register frees, holding off the next transaction
`default_nettype none

module max_heap_delete_largest_odd #(
    parameter int DEPTH       = mhdlo_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = mhdlo_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire mhdlo_pkg::t_in_item  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output mhdlo_pkg::t_out_item      o_out
);

    mhdlo_pkg::t_op   w_op;
    mhdlo_pkg::t_stat w_stat;

    // sequencer
    mhdlo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in.kind),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    // heap store and arithmetic
    mhdlo_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: test/mhdlo_checker.sv
`timescale 1ns / 100ps
// mhdlo_checker: watches both channels of the max-heap block, keeps its own heap copy,
// predicts every result and compares it field by field with what the block returns
// depends on mhdlo_pkg
module mhdlo_checker #(
    parameter int DEPTH = mhdlo_pkg::DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire mhdlo_pkg::t_in_item  i_in,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire mhdlo_pkg::t_out_item i_out,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_level
);
    import mhdlo_pkg::*;

    // heap copy and the results still owed by the block
    logic [15:0] heap_mem [DEPTH];
    int          heap_size = 0;
    int          fail_total = 0;
    t_out_item   owed_q [$];

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    function automatic void swap_slots(input int a, input int b);
        logic [15:0] held;
        held        = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = held;
    endfunction

    // move an entry toward the root while its parent is smaller
    function automatic void float_up(input int start);
        int pos;
        int parent;
        logic done;
        pos  = start;
        done = 1'b0;
        while (pos > 0 && !done) begin
            parent = (pos - 1) / 2;
            if (heap_mem[parent] >= heap_mem[pos]) begin
                done = 1'b1;
            end else begin
                swap_slots(pos, parent);
                pos = parent;
            end
        end
    endfunction

    // move an entry toward the leaves while a child is larger
    function automatic void sink_down(input int start);
        int pos;
        int best;
        int lchild;
        int rchild;
        logic done;
        pos  = start;
        done = 1'b0;
        while (!done) begin
            best   = pos;
            lchild = 2 * pos + 1;
            rchild = 2 * pos + 2;
            if (lchild < heap_size && heap_mem[lchild] > heap_mem[best]) best = lchild;
            if (rchild < heap_size && heap_mem[rchild] > heap_mem[best]) best = rchild;
            if (best == pos) begin
                done = 1'b1;
            end else begin
                swap_slots(pos, best);
                pos = best;
            end
        end
    endfunction

    // apply one operation to the heap copy and return the result it yields
    function automatic t_out_item apply_op(input t_in_item item);
        t_out_item res;
        logic      found;
        int        hole;
        int        k;
        res = '0;
        case (item.kind)
            KIND_INSERT: begin
                if (heap_size >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    heap_mem[heap_size] = item.item_value;
                    heap_size++;
                    float_up(heap_size - 1);
                end
            end
            KIND_DELETE: begin
                found = 1'b0;
                hole  = 0;
                // largest odd entry, lowest index on a tie
                for (k = 0; k < heap_size; k++) begin
                    if (heap_mem[k][0] && (!found || heap_mem[k] > heap_mem[hole])) begin
                        found = 1'b1;
                        hole  = k;
                    end
                end
                if (!found) begin
                    res.status = STAT_NO_ODD;
                end else begin
                    res.result_value = heap_mem[hole];
                    heap_size--;
                    // last entry fills the hole, then settles either way
                    if (hole < heap_size) begin
                        heap_mem[hole] = heap_mem[heap_size];
                        float_up(hole);
                        sink_down(hole);
                    end
                end
            end
            KIND_READ: begin
                if (int'(item.entry_index) >= heap_size) res.status = STAT_RANGE;
                else res.result_value = heap_mem[item.entry_index];
            end
            default: begin
                // spare kind code does nothing
            end
        endcase
        res.heap_count = 5'(heap_size);
        return res;
    endfunction

    // compare result transactions, then fold in the accepted input transaction
    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            owed_q.delete();
            heap_size = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch($sformatf("result with none owed: value %0d status %0d count %0d",
                                              i_out.result_value, i_out.status, i_out.heap_count));
                end else begin
                    want = owed_q.pop_front();
                    if (i_out.result_value !== want.result_value)
                        report_mismatch($sformatf("result_value got %0d expected %0d",
                                                  i_out.result_value, want.result_value));
                    if (i_out.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  i_out.status, want.status));
                    if (i_out.heap_count !== want.heap_count)
                        report_mismatch($sformatf("heap_count got %0d expected %0d",
                                                  i_out.heap_count, want.heap_count));
                end
            end
            if (i_in_valid && i_in_ready) owed_q.push_back(apply_op(i_in));
        end
        o_pending <= owed_q.size();
        o_level   <= heap_size;
    end

endmodule

FILE: test/tb_max_heap_delete_largest_odd.sv
`timescale 1ns / 100ps
// tb_max_heap_delete_largest_odd: clock, reset, stimulus and verdict for the max-heap block
// depends on mhdlo_pkg, max_heap_delete_largest_odd and mhdlo_checker
module tb_max_heap_delete_largest_odd;
    import mhdlo_pkg::*;

    localparam int         DEPTH        = DEPTH_DEF;
    localparam logic [1:0] KIND_SPARE   = 2'd3;    // unused kind code, no operation
    localparam int         RANDOM_ITEMS = 1300;
    localparam int         PHASE_LEN    = 100;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         CYCLE_LIMIT  = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int   fail_count;
    int   pending;
    int   level;
    int   cycles = 0;
    logic calm = 1'b0;      // no gaps on either side
    int   holds_asked = 0;
    int   holds_done = 0;
    int   even_left = 4;    // even values never leave the heap, so keep them rare

    max_heap_delete_largest_odd DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    mhdlo_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_level      (level)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [1:0] kind, input logic [15:0] value,
                                           input logic [3:0] index);
        t_in_item item;
        item.kind        = kind;
        item.item_value  = value;
        item.entry_index = index;
        return item;
    endfunction

    // mostly odd values, small ones for ties, a few evens and the extremes
    function automatic logic [15:0] draw_value();
        int          sel;
        logic [15:0] val;
        sel = $urandom_range(0, 19);
        if (sel == 0 && even_left > 0) begin
            val = 16'($urandom) & 16'hFFFE;
            even_left--;
        end else if (sel < 5) begin
            val = 16'($urandom_range(0, 15)) | 16'h0001;
        end else if (sel == 5) begin
            val = 16'hFFFF;
        end else if (sel == 6) begin
            val = 16'h0001;
        end else begin
            val = 16'($urandom) | 16'h0001;
        end
        return val;
    endfunction

    // random transaction, insert share set by the current phase
    function automatic t_in_item pick_item(input int insert_pct);
        t_in_item item;
        int       roll;
        item = make_item(KIND_DELETE, 16'($urandom), 4'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            item.kind       = KIND_INSERT;
            item.item_value = draw_value();
        end else if (roll < 85) begin
            item.kind = KIND_DELETE;
        end else if (roll < 97) begin
            item.kind = KIND_READ;
            if ($urandom_range(0, 2) != 0 && level > 0)
                item.entry_index = 4'($urandom_range(0, level - 1));
        end else begin
            item.kind = KIND_SPARE;
        end
        return item;
    endfunction

    // offer one transaction after a random gap and hold it until taken
    task automatic send_item(input t_in_item item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  = item;
        in_valid = 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls per transaction, long hold-offs on request
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (holds_done < holds_asked) begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int          i;
        int          phase;
        int          insert_pct;
        logic [15:0] fill_vals [12];
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        fill_vals = '{16'd7, 16'd7, 16'd3, 16'h8001, 16'h7FFF, 16'd5,
                      16'd9, 16'h5555, 16'hAAAB, 16'h00FF, 16'd11, 16'd13};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty heap, spare code, heap of evens only
        send_item(make_item(KIND_DELETE, 16'hFFFF, 4'hF));
        send_item(make_item(KIND_READ, 16'h0000, 4'h0));
        send_item(make_item(KIND_SPARE, 16'hA5A5, 4'hA));
        send_item(make_item(KIND_INSERT, 16'h0000, 4'h5));
        send_item(make_item(KIND_DELETE, 16'h0000, 4'h0));
        // extremes, then fill to capacity with odd values and a tie
        send_item(make_item(KIND_INSERT, 16'hFFFF, 4'hF));
        send_item(make_item(KIND_INSERT, 16'h0001, 4'h0));
        send_item(make_item(KIND_INSERT, 16'hFFFE, 4'h3));
        for (i = 0; i < 12; i++)
            send_item(make_item(KIND_INSERT, fill_vals[i], 4'($urandom)));
        // insert while full, reads at both ends, deletes from a full heap
        send_item(make_item(KIND_INSERT, 16'h1234, 4'h0));
        send_item(make_item(KIND_READ, 16'hFFFF, 4'hF));
        send_item(make_item(KIND_READ, 16'h5A5A, 4'h0));
        send_item(make_item(KIND_DELETE, 16'h0000, 4'h0));
        send_item(make_item(KIND_DELETE, 16'h0000, 4'h0));

        // random phases: filling, draining, balanced; every fourth phase without gaps
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            phase = i / PHASE_LEN;
            calm  = (phase % 4) == 3;
            case (phase % 3)
                0:       insert_pct = 65;
                1:       insert_pct = 28;
                default: insert_pct = 48;
            endcase
            if (i == 200 || i == 850) holds_asked++;
            send_item(pick_item(insert_pct));
        end
        in_valid = 1'b0;
        calm     = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
